// File: sv/ps2sa_pkg.sv
`default_nettype none
package ps2sa_pkg;

  // scan code values
  localparam logic [7:0] SC_ACK      = 8'hFA;
  localparam logic [7:0] SC_BAT_OK   = 8'hAA;
  localparam logic [7:0] SC_PFX_E0   = 8'hE0;
  localparam logic [7:0] SC_PFX_E1   = 8'hE1;
  localparam logic [6:0] SC_LSHIFT   = 7'h2A;
  localparam logic [6:0] SC_RSHIFT   = 7'h36;
  localparam logic [6:0] SC_CTRL     = 7'h1D;
  localparam logic [6:0] SC_CAPS     = 7'h3A;
  localparam logic [6:0] SC_ENTER    = 7'h1C;
  localparam logic [6:0] SC_BKSP     = 7'h0E;
  localparam logic [6:0] SC_UP       = 7'h48;
  localparam logic [6:0] SC_DOWN     = 7'h50;
  localparam logic [6:0] SC_LEFT     = 7'h4B;
  localparam logic [6:0] SC_RIGHT    = 7'h4D;
  localparam logic [6:0] SC_HOME     = 7'h47;
  localparam logic [6:0] SC_END      = 7'h4F;
  localparam logic [6:0] SC_PGUP     = 7'h49;
  localparam logic [6:0] SC_PGDN     = 7'h51;
  localparam logic [6:0] SC_INS      = 7'h52;
  localparam logic [6:0] SC_DEL      = 7'h53;

  // ascii values
  localparam logic [6:0] CH_ESC      = 7'h1B;
  localparam logic [6:0] CH_LBRACKET = 7'h5B;
  localparam logic [6:0] CH_TILDE    = 7'h7E;
  localparam logic [6:0] CH_LF       = 7'h0A;
  localparam logic [6:0] CH_BS       = 7'h08;
  localparam logic [6:0] CTRL_MASK   = 7'h1F;

  // lower half of the four key tables (codes 0x00 to 0x3f)
  localparam logic [6:0] LO_PLAIN [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };
  localparam logic [6:0] LO_SHIFT [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };
  localparam logic [6:0] LO_CAPS [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };
  localparam logic [6:0] LO_CAPS_SHIFT [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // table select codes: {caps, shift}
  localparam logic [1:0] TBL_PLAIN      = 2'd0;
  localparam logic [1:0] TBL_SHIFT      = 2'd1;
  localparam logic [1:0] TBL_CAPS       = 2'd2;
  localparam logic [1:0] TBL_CAPS_SHIFT = 2'd3;

  // one run of up to four characters produced by one scan byte
  typedef struct packed {
    logic            vld;
    logic [1:0]      last_idx;
    logic [3:0][6:0] chars;
  } run_t;

  // key table lookup, upper half is shared apart from a few keypad entries
  function automatic logic [6:0] key_lookup(input logic [1:0] sel, input logic [6:0] code);
    logic [6:0] lo;
    logic [6:0] hi;
    unique case (sel)
      TBL_PLAIN:  lo = LO_PLAIN[code[5:0]];
      TBL_SHIFT:  lo = LO_SHIFT[code[5:0]];
      TBL_CAPS:   lo = LO_CAPS[code[5:0]];
      default:    lo = LO_CAPS_SHIFT[code[5:0]];
    endcase
    hi = 7'h00;
    if (code == 7'h50) begin
      hi = 7'h1B;
    end else if (code == 7'h5B) begin
      hi = (sel == TBL_SHIFT) ? 7'h08 : 7'h0E;
    end else if (code == 7'h5C) begin
      hi = (sel == TBL_SHIFT) ? 7'h0A : 7'h1C;
    end else if (code == 7'h65) begin
      hi = (sel == TBL_CAPS_SHIFT) ? 7'h3F : 7'h2F;
    end else if (code[6:3] == 4'hF) begin
      hi = 7'h1E + {4'd0, code[2:0]};
    end
    return code[6] ? hi : lo;
  endfunction

endpackage
`default_nettype wire

// File: sv/ps2_scancode_to_ascii_unit.sv
`default_nettype none
// Set-1 scan code to ascii converter. Each scan byte taken on the in_ side
// yields zero to four ascii words on the out_ side, one word per cycle while
// out_tready is high, with tlast on the final word of each byte's run. A byte
// passes an input register and is decoded combinationally into a run register
// of up to four characters; a new byte can be taken every cycle as long as the
// output side keeps up, and a run holds the run register until its final word
// is taken (four words for the page, insert and delete keys). Bytes that give
// nothing (modifiers, break codes, prefixes, acknowledge) load no run.
module ps2_scancode_to_ascii_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] scan_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] char_byte, [7] zero
  output logic            out_tlast   // last_of_run
);
  import ps2sa_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_acc;
  logic       take;
  logic       free;
  logic       load;
  run_t       run;

  assign take      = in_vld_r && free;
  assign in_tready = !in_vld_r || take;
  assign in_acc    = in_tvalid && in_tready;
  assign load      = take && run.vld;

  // input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (take) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
    end
  end

  ps2sa_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (take),
    .byte_i (in_byte_r),
    .run_o  (run)
  );

  ps2sa_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .run_i      (run),
    .free_o     (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a decoded run shows up on the output the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("decoded run not presented");

  // the input side only stalls while a byte waits in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_vld_r && !free)
    else $error("input stalled without a pending byte");

  // after the final word of a run is taken with nothing new loaded, output goes idle
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast && !load |=> !out_tvalid)
    else $error("output valid after end of run");

  // a run is never loaded over one still in progress
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_tvalid |-> out_tready && out_tlast)
    else $error("run overwritten before drained");

endmodule
`default_nettype wire

// File: sv/ps2sa_decode.sv
`default_nettype none
module ps2sa_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take_i,
  input  wire logic [7:0]       byte_i,
  output ps2sa_pkg::run_t       run_o
);
  import ps2sa_pkg::*;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_E0   = 2'd1;
  localparam logic [1:0] PH_E1   = 2'd2;
  localparam logic [1:0] PH_E1B  = 2'd3;

  logic       shift_r, shift_nxt;
  logic       ctrl_r, ctrl_nxt;
  logic       caps_r, caps_nxt;
  logic       ack_r, ack_nxt;
  logic       bat_r, bat_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [6:0] code;
  logic [6:0] ch;
  logic [6:0] ch_m;
  run_t       run;

  assign code = byte_i[6:0];
  assign ch   = key_lookup({caps_r, shift_r}, code);
  assign ch_m = ctrl_r ? (ch & CTRL_MASK) : ch;

  // decode one byte and work out the modifier and prefix state
  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    caps_nxt  = caps_r;
    ack_nxt   = ack_r;
    bat_nxt   = bat_r;
    phase_nxt = phase_r;
    run.vld      = 1'b0;
    run.last_idx = 2'd0;
    run.chars[0] = CH_ESC;
    run.chars[1] = CH_LBRACKET;
    run.chars[2] = 7'h00;
    run.chars[3] = CH_TILDE;
    if (take_i) begin
      unique case (phase_r)
        PH_E0: begin
          // extended key: vt escape sequence
          phase_nxt = PH_NONE;
          run.vld      = 1'b1;
          run.last_idx = 2'd2;
          priority case (code & {7{~byte_i[7]}})
            SC_UP:    run.chars[2] = 7'h41;
            SC_DOWN:  run.chars[2] = 7'h42;
            SC_LEFT:  run.chars[2] = 7'h44;
            SC_RIGHT: run.chars[2] = 7'h43;
            SC_HOME:  run.chars[2] = 7'h48;
            SC_END:   run.chars[2] = 7'h46;
            SC_PGUP: begin
              run.chars[2] = 7'h35;
              run.last_idx = 2'd3;
            end
            SC_PGDN: begin
              run.chars[2] = 7'h36;
              run.last_idx = 2'd3;
            end
            SC_INS: begin
              run.chars[2] = 7'h32;
              run.last_idx = 2'd3;
            end
            SC_DEL: begin
              run.chars[2] = 7'h33;
              run.last_idx = 2'd3;
            end
            default: run.vld = 1'b0;
          endcase
        end
        PH_E1:  phase_nxt = PH_E1B;
        PH_E1B: phase_nxt = PH_NONE;
        default: begin
          priority if (byte_i == SC_ACK) begin
            ack_nxt = 1'b1;
          end else if (byte_i == SC_BAT_OK && ack_r && !bat_r) begin
            bat_nxt = 1'b1;
          end else if (byte_i == SC_PFX_E0) begin
            phase_nxt = PH_E0;
          end else if (byte_i == SC_PFX_E1) begin
            phase_nxt = PH_E1;
          end else if (byte_i[7]) begin
            // break codes release shift and ctrl
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
              shift_nxt = 1'b0;
            end
            if (code == SC_CTRL) begin
              ctrl_nxt = 1'b0;
            end
          end else if (ch != 7'h00) begin
            run.vld      = (ch_m != 7'h00);
            run.chars[0] = ch_m;
          end else begin
            // keys with no table entry
            if (code == SC_ENTER) begin
              run.vld      = 1'b1;
              run.chars[0] = CH_LF;
            end else if (code == SC_BKSP) begin
              run.vld      = 1'b1;
              run.chars[0] = CH_BS;
            end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
              shift_nxt = 1'b1;
            end else if (code == SC_CTRL) begin
              ctrl_nxt = 1'b1;
            end else if (code == SC_CAPS) begin
              caps_nxt = ~caps_r;
            end
          end
        end
      endcase
    end
  end

  assign run_o = run;

  // keyboard state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      caps_r  <= 1'b0;
      ack_r   <= 1'b0;
      bat_r   <= 1'b0;
      phase_r <= PH_NONE;
    end else begin
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      caps_r  <= caps_nxt;
      ack_r   <= ack_nxt;
      bat_r   <= bat_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/ps2sa_emit.sv
`default_nettype none
module ps2sa_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load_i,
  input  wire ps2sa_pkg::run_t  run_i,
  output logic                  free_o,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);
  import ps2sa_pkg::*;

  logic            vld_r, vld_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [1:0]      last_idx_r;
  logic [3:0][6:0] chars_r;
  logic            last;
  logic            pop;

  assign last       = (idx_r == last_idx_r);
  assign pop        = vld_r && out_tready;
  assign free_o     = !vld_r || (out_tready && last);
  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, chars_r[idx_r]};
  assign out_tlast  = last;

  // run occupancy and character index
  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load_i) begin
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (pop) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (load_i) begin
      chars_r    <= run_i.chars;
      last_idx_r <= run_i.last_idx;
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_ps2_scancode_to_ascii_unit.sv
`timescale 1ns / 1ps
module tb_ps2_scancode_to_ascii_unit;
  import ps2sa_pkg::*;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       in_tvalid   = 1'b0;
  logic [7:0] in_tdata    = 8'h00;
  logic       out_tready  = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;

  ps2_scancode_to_ascii_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // lower half of the unshifted and shifted key rows (codes 0x00 to 0x3f)
  localparam logic [6:0] UNSHIFTED_ROW [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };
  localparam logic [6:0] SHIFTED_ROW [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // keys that have an escape sequence after the E0 prefix
  localparam logic [7:0] NAV_KEYS [10] = '{
    {1'b0, SC_UP}, {1'b0, SC_DOWN}, {1'b0, SC_LEFT}, {1'b0, SC_RIGHT},
    {1'b0, SC_HOME}, {1'b0, SC_END}, {1'b0, SC_PGUP}, {1'b0, SC_PGDN},
    {1'b0, SC_INS}, {1'b0, SC_DEL}
  };
  localparam logic [7:0] MOD_KEYS [4] = '{
    {1'b0, SC_LSHIFT}, {1'b0, SC_RSHIFT}, {1'b0, SC_CTRL}, {1'b0, SC_CAPS}
  };

  typedef enum logic [1:0] {
    PFX_NONE, PFX_AFTER_E0, PFX_AFTER_E1, PFX_E1_TAIL
  } pfx_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } char_word_t;

  // predicted keyboard state
  logic shift_dn;
  logic ctrl_dn;
  logic caps_lock;
  logic ack_flag;
  logic bat_swallowed;
  pfx_t pfx;

  char_word_t pending_chars [$];
  char_word_t want;
  int         mismatch_cnt  = 0;
  int         chars_checked = 0;
  int         runs_checked  = 0;
  int         bytes_sent    = 0;
  int         directed_cnt  = 0;
  int         idle_pct      = 0;
  int         stall_pct     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // character a make code selects in the current caps and shift mode
  function automatic logic [6:0] key_char(input logic caps, input logic shift,
                                          input logic [6:0] code);
    logic [6:0] ch;
    ch = 7'h00;
    if (!code[6]) begin
      ch = shift ? SHIFTED_ROW[code[5:0]] : UNSHIFTED_ROW[code[5:0]];
      // caps lock flips the case of letters only
      if (caps && ch >= 7'h61 && ch <= 7'h7A) ch = ch - 7'h20;
      else if (caps && ch >= 7'h41 && ch <= 7'h5A) ch = ch + 7'h20;
      // the shifted row's newline slot is empty with caps on
      if (caps && shift && code == SC_ENTER) ch = 7'h00;
    end else begin
      // keypad area, mostly the same in every mode
      if (code == 7'h50) ch = CH_ESC;
      else if (code == 7'h5B) ch = (shift && !caps) ? CH_BS : 7'h0E;
      else if (code == 7'h5C) ch = (shift && !caps) ? CH_LF : 7'h1C;
      else if (code == 7'h65) ch = (shift && caps) ? 7'h3F : 7'h2F;
      else if (code[6:3] == 4'hF) ch = 7'h1E + {4'd0, code[2:0]};
    end
    return ch;
  endfunction

  function automatic void push_char(input logic [6:0] ch, input logic last);
    char_word_t w;
    w.ch   = ch;
    w.last = last;
    pending_chars.push_back(w);
  endfunction

  // escape sequence for the byte that follows E0
  function automatic void push_escape(input logic [7:0] b);
    logic [7:0] key;
    logic       tilde;
    key   = 8'h00;
    tilde = 1'b0;
    case (b)
      SC_UP:    key = "A";
      SC_DOWN:  key = "B";
      SC_LEFT:  key = "D";
      SC_RIGHT: key = "C";
      SC_HOME:  key = "H";
      SC_END:   key = "F";
      SC_PGUP:  begin key = "5"; tilde = 1'b1; end
      SC_PGDN:  begin key = "6"; tilde = 1'b1; end
      SC_INS:   begin key = "2"; tilde = 1'b1; end
      SC_DEL:   begin key = "3"; tilde = 1'b1; end
      default:  key = 8'h00;
    endcase
    if (key != 8'h00) begin
      push_char(CH_ESC, 1'b0);
      push_char(CH_LBRACKET, 1'b0);
      push_char(key[6:0], !tilde);
      if (tilde) push_char(CH_TILDE, 1'b1);
    end
  endfunction

  // advance the keyboard state by one scan byte and queue its characters
  function automatic void decode_scan_byte(input logic [7:0] b);
    logic [6:0] code;
    logic [6:0] ch;
    code = b[6:0];
    // prefix operands bypass everything else
    if (pfx == PFX_AFTER_E0) begin
      pfx = PFX_NONE;
      push_escape(b);
    end else if (pfx == PFX_AFTER_E1) begin
      pfx = PFX_E1_TAIL;
    end else if (pfx == PFX_E1_TAIL) begin
      pfx = PFX_NONE;
    end else if (b == SC_ACK) begin
      ack_flag = 1'b1;
    end else if (b == SC_BAT_OK && ack_flag && !bat_swallowed) begin
      bat_swallowed = 1'b1;
    end else if (b == SC_PFX_E0) begin
      pfx = PFX_AFTER_E0;
    end else if (b == SC_PFX_E1) begin
      pfx = PFX_AFTER_E1;
    end else if (b[7]) begin
      // break codes only release held modifiers
      if (shift_dn && (code == SC_LSHIFT || code == SC_RSHIFT)) shift_dn = 1'b0;
      else if (ctrl_dn && code == SC_CTRL) ctrl_dn = 1'b0;
    end else begin
      ch = key_char(caps_lock, shift_dn, code);
      if (ch != 7'h00) begin
        if (ctrl_dn) ch = ch & CTRL_MASK;
        if (ch != 7'h00) push_char(ch, 1'b1);
      end else if (code == SC_ENTER) begin
        push_char(CH_LF, 1'b1);
      end else if (code == SC_BKSP) begin
        push_char(CH_BS, 1'b1);
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        shift_dn = 1'b1;
      end else if (code == SC_CTRL) begin
        ctrl_dn = 1'b1;
      end else if (code == SC_CAPS) begin
        caps_lock = !caps_lock;
      end
    end
  endfunction

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each output word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected word, expected none, got tdata %h tlast %b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_tlast) runs_checked++;
        if (out_tdata !== {1'b0, want.ch} || out_tlast !== want.last) begin
          mismatch_cnt++;
          $display("%0t: mismatch, expected tdata %h tlast %b, got tdata %h tlast %b",
                   $time, {1'b0, want.ch}, want.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // offer one scan byte, with random idle cycles ahead of it
  task automatic send_scan(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_scan_byte(b);
    bytes_sent++;
  endtask

  // table extremes, enter and the top keypad slot
  task automatic test_plain_keys();
    send_scan(8'h00);
    send_scan(8'h1E);
    send_scan({1'b0, SC_ENTER});
    send_scan(8'h7F);
  endtask

  // shift, caps lock and ctrl, including a zero result after masking
  task automatic test_modifiers();
    send_scan({1'b0, SC_LSHIFT});
    send_scan({1'b0, SC_CAPS});
    send_scan({1'b0, SC_ENTER});
    send_scan(SC_BAT_OK);
    send_scan(8'h10);
    send_scan({1'b0, SC_CAPS});
    send_scan({1'b0, SC_CTRL});
    send_scan(8'h2E);
    send_scan(8'h39);
    send_scan({1'b1, SC_CTRL});
  endtask

  // E0 page and cursor keys, an unmapped E0 operand and an E1 pause sequence
  task automatic test_prefixes();
    send_scan(SC_PFX_E0);
    send_scan({1'b0, SC_PGUP});
    send_scan(SC_PFX_E0);
    send_scan({1'b0, SC_PGDN});
    send_scan(SC_PFX_E0);
    send_scan({1'b0, SC_UP});
    send_scan(SC_PFX_E0);
    send_scan({1'b1, SC_CTRL});
    send_scan(SC_PFX_E1);
    send_scan({1'b0, SC_CTRL});
    send_scan(8'h45);
  endtask

  // acknowledge, then one swallowed reset reply, then a plain one
  task automatic test_ack_reply();
    send_scan(SC_ACK);
    send_scan(SC_BAT_OK);
    send_scan(SC_BAT_OK);
  endtask

  // one random keystroke sequence, mostly well formed
  task automatic random_keystroke();
    int         pick;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 45) begin
      code = 8'($urandom_range(127));
      send_scan(code);
      if ($urandom_range(1)) send_scan(code | 8'h80);
    end else if (pick < 60) begin
      code = MOD_KEYS[$urandom_range(3)];
      send_scan($urandom_range(1) ? code : (code | 8'h80));
    end else if (pick < 80) begin
      send_scan(SC_PFX_E0);
      send_scan(pick < 75 ? NAV_KEYS[$urandom_range(9)] : 8'($urandom_range(255)));
    end else if (pick < 88) begin
      send_scan(SC_PFX_E1);
      send_scan(8'($urandom_range(255)));
      send_scan(8'($urandom_range(255)));
    end else begin
      send_scan(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_phase(input int sender_idle, input int receiver_stall,
                                   input int n_bytes);
    int stop_at;
    stop_at   = bytes_sent + n_bytes;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    while (bytes_sent < stop_at) random_keystroke();
  endtask

  // sequence of tests
  initial begin
    shift_dn      = 1'b0;
    ctrl_dn       = 1'b0;
    caps_lock     = 1'b0;
    ack_flag      = 1'b0;
    bat_swallowed = 1'b0;
    pfx           = PFX_NONE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_keys();
    test_modifiers();
    test_prefixes();
    test_ack_reply();
    directed_cnt = bytes_sent;

    test_random_phase(0, 0, 38);
    test_random_phase(45, 0, 38);
    test_random_phase(0, 45, 38);
    test_random_phase(18, 18, 38);
    in_tvalid <= 1'b0;

    // drain, then give the pipeline time to show stray words
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d scan bytes (%0d directed), checked %0d ascii words in %0d runs",
             bytes_sent, directed_cnt, chars_checked, runs_checked);
    $display("modifiers, E0/E1 prefixes and ack/reset reply under sender and receiver stalls");
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
